>>> design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SUCP_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define SUCP_ASSERT(lbl, prop) `SUCP_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)
`else
`define SUCP_ASSERT_CLK(lbl, clk, rstn, prop)
`define SUCP_ASSERT(lbl, prop)
`endif
`endif

>>> design/sucp_pkg.sv
// Shared constants, types and stage map of the scaled unit cross product pipeline.
package sucp_pkg;
    localparam int CW       = 32;          // component width
    localparam int MAG_W    = 2 * CW;      // cross component magnitude
    localparam int N_W      = CW - 1;      // normalized magnitude
    localparam int NUM_W    = 2 * CW - 2;  // |m| * n
    localparam int SQ_W     = 2 * N_W;     // n * n
    localparam int LEN_W    = CW;          // vector length
    localparam int Q_W      = CW + 1;      // truncated quotient
    localparam int BL_W     = 7;           // bit length of a magnitude

    localparam int SQRT_STAGES = LEN_W;
    localparam int SQRT_LAT    = SQRT_STAGES + 1;
    localparam int DIV_STAGES  = Q_W;

    // stage map (index of the valid bit)
    localparam int ST_N      = 6;                      // normalized magnitudes
    localparam int ST_E      = 7;                      // products and squares
    localparam int ST_LEN    = ST_E + SQRT_LAT;        // length ready
    localparam int ST_DIV    = ST_LEN + DIV_STAGES;    // last divider step
    localparam int ST_OUT    = ST_DIV + 1;             // output register
    localparam int N_STAGES  = ST_OUT + 1;

    typedef logic [MAG_W-1:0] t_mag;
    typedef logic [N_W-1:0]   t_norm;
    typedef logic [LEN_W-1:0] t_len;

    typedef struct packed {
        logic en;
        logic deg;
        logic m_neg;
    } t_lane_ctl;
endpackage

>>> design/sucp_cross.sv
// One cross product lane: two signed products, difference, magnitude and sign.
module sucp_cross (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [sucp_pkg::CW-1:0] i_p,
    input  logic signed [sucp_pkg::CW-1:0] i_q,
    input  logic signed [sucp_pkg::CW-1:0] i_r,
    input  logic signed [sucp_pkg::CW-1:0] i_s,
    output sucp_pkg::t_mag           o_mag,
    output logic                     o_neg
);
    import sucp_pkg::*;

    logic signed [MAG_W-1:0] r_m0, r_m1;
    logic signed [MAG_W-1:0] w_d;
    t_mag r_mag;
    logic r_neg;

    assign w_d = r_m0 - r_m1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0  <= i_p * i_q;
            r_m1  <= i_r * i_s;
            r_neg <= w_d[MAG_W-1];
            r_mag <= w_d[MAG_W-1] ? t_mag'(-w_d) : t_mag'(w_d);
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;
endmodule

>>> design/sucp_norm.sv
// Merge stage: largest magnitude, its bit length, and common normalizing shift.
module sucp_norm (
    input  logic            i_clk,
    input  logic            i_en,
    input  sucp_pkg::t_mag  i_mag [3],
    input  logic [2:0]      i_neg,
    output sucp_pkg::t_norm o_n [3],
    output logic [2:0]      o_neg,
    output logic            o_deg
);
    import sucp_pkg::*;

    t_mag r_m1 [3];
    t_mag r_m2 [3];
    t_mag r_m3 [3];
    logic [2:0] r_s1, r_s2, r_s3, r_s4;
    logic r_d1, r_d2, r_d3, r_d4;
    t_mag r_big;
    logic [2:0] r_bidx;
    logic [7:0] r_byte;
    logic [BL_W-1:0] r_bl;
    t_norm r_n [3];

    t_mag w_big;
    logic [2:0] w_bidx;
    logic [7:0] w_byte;
    logic [3:0] w_pos;
    logic [BL_W-1:0] w_bl;
    t_norm w_n [3];

    always_comb begin
        w_big = i_mag[0];
        if (i_mag[1] > w_big) w_big = i_mag[1];
        if (i_mag[2] > w_big) w_big = i_mag[2];
    end

    // highest nonzero byte
    always_comb begin
        w_bidx = '0;
        w_byte = '0;
        for (int i = 0; i < 8; i++) begin
            if (r_big[8*i +: 8] != 8'd0) begin
                w_bidx = 3'(i);
                w_byte = r_big[8*i +: 8];
            end
        end
    end

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < 8; i++) begin
            if (r_byte[i]) w_pos = 4'(i + 1);
        end
        w_bl = (r_byte == 8'd0) ? '0 : BL_W'({r_bidx, 3'b000}) + BL_W'(w_pos);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_bl > BL_W'(N_W)) begin
                w_n[i] = N_W'(r_m3[i] >> (r_bl - BL_W'(N_W)));
            end else begin
                w_n[i] = N_W'(r_m3[i] << (BL_W'(N_W) - r_bl));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= i_mag;
            r_s1   <= i_neg;
            r_big  <= w_big;
            r_d1   <= (i_mag[0] == '0) && (i_mag[1] == '0) && (i_mag[2] == '0);
            r_m2   <= r_m1;
            r_s2   <= r_s1;
            r_d2   <= r_d1;
            r_bidx <= w_bidx;
            r_byte <= w_byte;
            r_m3   <= r_m2;
            r_s3   <= r_s2;
            r_d3   <= r_d2;
            r_bl   <= w_bl;
            r_n    <= w_n;
            r_s4   <= r_s3;
            r_d4   <= r_d3;
        end
    end

    assign o_n   = r_n;
    assign o_neg = r_s4;
    assign o_deg = r_d4;
endmodule

>>> design/sucp_sqrt.sv
// Sum of squares and pipelined integer square root, one result bit per stage.
module sucp_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sucp_pkg::SQ_W-1:0]   i_sq [3],
    output sucp_pkg::t_len              o_len
);
    import sucp_pkg::*;

    logic [MAG_W-1:0] r_sum;
    logic [LEN_W:0]   r_rem  [SQRT_STAGES];
    t_len             r_root [SQRT_STAGES];
    logic [MAG_W-1:0] r_v    [SQRT_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= MAG_W'(i_sq[0]) + MAG_W'(i_sq[1]) + MAG_W'(i_sq[2]);
        end
    end

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_step
        logic [LEN_W:0]   w_rem_in;
        t_len             w_root_in;
        logic [MAG_W-1:0] w_v_in;
        logic [LEN_W+2:0] w_t, w_trial;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_v_in    = r_sum;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
            assign w_v_in    = r_v[j-1];
        end

        assign w_t     = {w_rem_in, w_v_in[MAG_W-1-2*j -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= w_ge ? (LEN_W+1)'(w_t - w_trial) : (LEN_W+1)'(w_t);
                r_root[j] <= {w_root_in[LEN_W-2:0], w_ge};
                r_v[j]    <= w_v_in;
            end
        end
    end

    assign o_len = r_root[SQRT_STAGES-1];
endmodule

>>> design/sucp_scale.sv
// One output lane: |m|*n and n*n, delay across the root, long division, rounding.
module sucp_scale (
    input  logic                          i_clk,
    input  sucp_pkg::t_lane_ctl           i_ctl,
    input  logic [sucp_pkg::CW-1:0]       i_mmag,
    input  sucp_pkg::t_norm               i_n,
    input  logic                          i_nneg,
    input  sucp_pkg::t_len                i_len,
    output logic [sucp_pkg::SQ_W-1:0]     o_sq,
    output logic [sucp_pkg::CW-1:0]       o_res
);
    import sucp_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [SQ_W-1:0]  r_sq;
    logic             r_ng;
    logic [NUM_W-1:0] r_dnum [SQRT_LAT];
    logic             r_dneg [SQRT_LAT];

    logic [LEN_W-1:0] r_rem  [DIV_STAGES];
    logic [Q_W-1:0]   r_q    [DIV_STAGES];
    logic [NUM_W-1:0] r_dv   [DIV_STAGES];
    t_len             r_len  [DIV_STAGES];
    logic             r_vneg [DIV_STAGES];

    logic [CW-1:0]    r_res;
    logic [NUM_W:0]   w_prod;
    logic             w_rnd;
    logic [Q_W:0]     w_q;
    logic             w_neg;
    logic [CW-1:0]    w_res;

    assign w_prod = (NUM_W+1)'(i_mmag) * (NUM_W+1)'(i_n);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_num <= w_prod[NUM_W-1:0];
            r_sq  <= i_n * i_n;
            r_ng  <= i_nneg;
            r_dnum[0] <= r_num;
            r_dneg[0] <= r_ng;
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_dnum[k] <= r_dnum[k-1];
                r_dneg[k] <= r_dneg[k-1];
            end
        end
    end

    // restoring division, one quotient bit per stage, high bits known zero
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [LEN_W-1:0] w_rem_in;
        logic [Q_W-1:0]   w_q_in;
        logic [NUM_W-1:0] w_num_in;
        t_len             w_len_in;
        logic             w_neg_in;
        logic [LEN_W:0]   w_t;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = LEN_W'(r_dnum[SQRT_LAT-1][NUM_W-1:Q_W]);
            assign w_q_in   = '0;
            assign w_num_in = r_dnum[SQRT_LAT-1];
            assign w_len_in = i_len;
            assign w_neg_in = r_dneg[SQRT_LAT-1];
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_q_in   = r_q[j-1];
            assign w_num_in = r_dv[j-1];
            assign w_len_in = r_len[j-1];
            assign w_neg_in = r_vneg[j-1];
        end

        assign w_t  = {w_rem_in, w_num_in[Q_W-1-j]};
        assign w_ge = (w_t >= {1'b0, w_len_in});

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[j]  <= w_ge ? LEN_W'(w_t - {1'b0, w_len_in}) : LEN_W'(w_t);
                r_q[j]    <= {w_q_in[Q_W-2:0], w_ge};
                r_dv[j]   <= w_num_in;
                r_len[j]  <= w_len_in;
                r_vneg[j] <= w_neg_in;
            end
        end
    end

    // round half away from zero, apply sign, saturate
    always_comb begin
        w_rnd = ({r_rem[DIV_STAGES-1], 1'b0} >= {1'b0, r_len[DIV_STAGES-1]});
        w_q   = (Q_W+1)'(r_q[DIV_STAGES-1]) + (Q_W+1)'(w_rnd);
        w_neg = (i_ctl.m_neg != r_vneg[DIV_STAGES-1]) && (w_q != '0);
        if (i_ctl.deg) begin
            w_res = '0;
        end else if (w_neg) begin
            if (w_q > (Q_W+1)'(1) << (CW-1)) w_res = {1'b1, {(CW-1){1'b0}}};
            else                             w_res = CW'(~w_q + 1'b1);
        end else begin
            if (w_q > ((Q_W+1)'(1) << (CW-1)) - 1'b1) w_res = {1'b0, {(CW-1){1'b1}}};
            else                                     w_res = CW'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_res <= w_res;
        end
    end

    assign o_sq  = r_sq;
    assign o_res = r_res;
endmodule

>>> design/scaled_unit_cross_product_unit.sv
// Throughput: one transaction per cycle; the 32-step root and 33-step divider
// are fully pipelined, one bit per stage.
// Backpressure stalls the whole pipe; the input register still fills while stalled if it holds no valid transaction.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
// Top level: input register, three cross lanes, merge/normalize, root, three scale/divide lanes, output register.
module scaled_unit_cross_product_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // ax, ay, az, bx, by_comp, bz, magnification (32 bits each, lowest first)
    input  logic [223:0]  i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // rx, ry, rz (32 bits each, lowest first)
    output logic [95:0]   o_m_tdata,
    // degenerate
    output logic [0:0]    o_m_tuser
);
    import sucp_pkg::*;

`include "assert_macros.svh"

    logic [N_STAGES-1:0] r_vld;
    logic                w_en;
    logic                w_ld0;

    // input register fields
    logic signed [CW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_m;

    // magnification path
    logic [CW-1:0] r_mmag [1:ST_N];
    logic          r_mneg [1:ST_DIV];
    logic          r_deg  [ST_N+1:ST_DIV];
    logic          r_deg_o;

    t_mag              w_mag [3];
    logic [2:0]        w_cneg;
    t_norm             w_n [3];
    logic [2:0]        w_nneg;
    logic              w_deg6;
    logic [SQ_W-1:0]   w_sq [3];
    t_len              w_len;
    logic [CW-1:0]     w_res [3];
    t_lane_ctl         w_ctl;

    // advance the pipe when the output register is empty or being taken
    assign w_en       = !r_vld[N_STAGES-1] || i_m_tready;
    assign w_ld0      = w_en || !r_vld[0];
    assign o_s_tready = w_ld0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld0) r_vld[0] <= i_s_tvalid;
            if (w_en)  r_vld[N_STAGES-1:1] <= r_vld[N_STAGES-2:0];
        end
    end

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (w_ld0 && i_s_tvalid) begin
            r_ax <= i_s_tdata[31:0];
            r_ay <= i_s_tdata[63:32];
            r_az <= i_s_tdata[95:64];
            r_bx <= i_s_tdata[127:96];
            r_by <= i_s_tdata[159:128];
            r_bz <= i_s_tdata[191:160];
            r_m  <= i_s_tdata[223:192];
        end
    end

    // hold magnitude and sign of the scale factor alongside the lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mmag[1] <= r_m[CW-1] ? CW'(-r_m) : CW'(r_m);
            r_mneg[1] <= r_m[CW-1];
            for (int k = 2; k <= ST_N; k++) r_mmag[k] <= r_mmag[k-1];
            for (int k = 2; k <= ST_DIV; k++) r_mneg[k] <= r_mneg[k-1];
            r_deg[ST_N+1] <= w_deg6;
            for (int k = ST_N + 2; k <= ST_DIV; k++) r_deg[k] <= r_deg[k-1];
            r_deg_o <= r_deg[ST_DIV];
        end
    end

    // cross product lanes
    sucp_cross u_cx (.i_clk, .i_en(w_en), .i_p(r_ay), .i_q(r_bz), .i_r(r_az), .i_s(r_by),
                     .o_mag(w_mag[0]), .o_neg(w_cneg[0]));
    sucp_cross u_cy (.i_clk, .i_en(w_en), .i_p(r_az), .i_q(r_bx), .i_r(r_ax), .i_s(r_bz),
                     .o_mag(w_mag[1]), .o_neg(w_cneg[1]));
    sucp_cross u_cz (.i_clk, .i_en(w_en), .i_p(r_ax), .i_q(r_by), .i_r(r_ay), .i_s(r_bx),
                     .o_mag(w_mag[2]), .o_neg(w_cneg[2]));

    // merge lanes: common shift to put the largest magnitude at 31 bits
    sucp_norm u_norm (
        .i_clk, .i_en(w_en), .i_mag(w_mag), .i_neg(w_cneg),
        .o_n(w_n), .o_neg(w_nneg), .o_deg(w_deg6)
    );

    assign w_ctl.en    = w_en;
    assign w_ctl.deg   = r_deg[ST_DIV];
    assign w_ctl.m_neg = r_mneg[ST_DIV];

    // scale lanes
    for (genvar i = 0; i < 3; i++) begin : g_lane
        sucp_scale u_scale (
            .i_clk, .i_ctl(w_ctl), .i_mmag(r_mmag[ST_N]), .i_n(w_n[i]),
            .i_nneg(w_nneg[i]), .i_len(w_len), .o_sq(w_sq[i]), .o_res(w_res[i])
        );
    end

    // vector length
    sucp_sqrt u_sqrt (.i_clk, .i_en(w_en), .i_sq(w_sq), .o_len(w_len));

    assign o_m_tvalid   = r_vld[N_STAGES-1];
    assign o_m_tdata    = {w_res[2], w_res[1], w_res[0]};
    assign o_m_tuser[0] = r_deg_o;

    `SUCP_ASSERT(a_deg_zero, (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
    `SUCP_ASSERT(a_hold_pipe, !w_en |=> $stable(r_vld[N_STAGES-1:1]))
    `SUCP_ASSERT(a_take_input, (i_s_tvalid && o_s_tready) |=> r_vld[0])
    `SUCP_ASSERT(a_drain, (o_m_tvalid && i_m_tready) |=> (o_m_tvalid == $past(r_vld[N_STAGES-2])))
endmodule
